// ===== src/lst_pkg.sv =====
// package for the sign-token lexer: character codes, pending-sign codes,
// token codes, the lexer state struct and the single-sign lookup
// no dependencies
`default_nettype none

package lst_pkg;

	localparam int unsigned CHAR_W  = 8;
	localparam int unsigned TOKEN_W = 5;
	localparam int unsigned PEND_W  = 3;

	// characters of interest
	localparam logic [CHAR_W-1:0] CH_COLON = 8'h3a;
	localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2a;
	localparam logic [CHAR_W-1:0] CH_EQ    = 8'h3d;
	localparam logic [CHAR_W-1:0] CH_AMP   = 8'h26;
	localparam logic [CHAR_W-1:0] CH_NL    = 8'h0a;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
	localparam logic [CHAR_W-1:0] CH_LT    = 8'h3c;
	localparam logic [CHAR_W-1:0] CH_GT    = 8'h3e;
	localparam logic [CHAR_W-1:0] CH_BANG  = 8'h21;
	localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3b;
	localparam logic [CHAR_W-1:0] CH_LPAR  = 8'h28;
	localparam logic [CHAR_W-1:0] CH_RPAR  = 8'h29;
	localparam logic [CHAR_W-1:0] CH_LBRC  = 8'h7b;
	localparam logic [CHAR_W-1:0] CH_RBRC  = 8'h7d;
	localparam logic [CHAR_W-1:0] CH_LBRK  = 8'h5b;
	localparam logic [CHAR_W-1:0] CH_RBRK  = 8'h5d;

	// pending first sign
	localparam logic [PEND_W-1:0] PS_NONE  = 3'd0;
	localparam logic [PEND_W-1:0] PS_COLON = 3'd1;
	localparam logic [PEND_W-1:0] PS_STAR  = 3'd2;
	localparam logic [PEND_W-1:0] PS_EQ    = 3'd3;
	localparam logic [PEND_W-1:0] PS_AMP   = 3'd4;

	// token codes
	localparam logic [TOKEN_W-1:0] TK_REJECT   = 5'd0;
	localparam logic [TOKEN_W-1:0] TK_CONT     = 5'd1;
	localparam logic [TOKEN_W-1:0] TK_CMT_BODY = 5'd2;
	localparam logic [TOKEN_W-1:0] TK_CMT_NL   = 5'd3;
	localparam logic [TOKEN_W-1:0] TK_CMT_END  = 5'd4;
	localparam logic [TOKEN_W-1:0] TK_PLUS     = 5'd5;
	localparam logic [TOKEN_W-1:0] TK_MINUS    = 5'd6;
	localparam logic [TOKEN_W-1:0] TK_COLON    = 5'd7;
	localparam logic [TOKEN_W-1:0] TK_STAR     = 5'd8;
	localparam logic [TOKEN_W-1:0] TK_LT       = 5'd9;
	localparam logic [TOKEN_W-1:0] TK_GT       = 5'd10;
	localparam logic [TOKEN_W-1:0] TK_EQ       = 5'd11;
	localparam logic [TOKEN_W-1:0] TK_ASSIGN   = 5'd12;
	localparam logic [TOKEN_W-1:0] TK_EQCEQ    = 5'd13;
	localparam logic [TOKEN_W-1:0] TK_BANG     = 5'd14;
	localparam logic [TOKEN_W-1:0] TK_ANDAND   = 5'd15;
	localparam logic [TOKEN_W-1:0] TK_SEMI     = 5'd16;
	localparam logic [TOKEN_W-1:0] TK_LPAR     = 5'd17;
	localparam logic [TOKEN_W-1:0] TK_RPAR     = 5'd18;
	localparam logic [TOKEN_W-1:0] TK_LBRC     = 5'd19;
	localparam logic [TOKEN_W-1:0] TK_RBRC     = 5'd20;
	localparam logic [TOKEN_W-1:0] TK_LBRK     = 5'd21;
	localparam logic [TOKEN_W-1:0] TK_RBRK     = 5'd22;

	typedef struct packed {
		logic [PEND_W-1:0] pending_sign;
		logic              second_colon;
		logic              in_comment;
	} lex_state_t;

	localparam lex_state_t LEX_RESET = '{pending_sign: PS_NONE, second_colon: 1'b0,
		in_comment: 1'b0};

	// single-character signs, reject when not one
	function automatic logic [TOKEN_W-1:0] single_sign(input logic [CHAR_W-1:0] c);
		logic [TOKEN_W-1:0] t;
		case (c)
			CH_PLUS:  t = TK_PLUS;
			CH_MINUS: t = TK_MINUS;
			CH_LT:    t = TK_LT;
			CH_GT:    t = TK_GT;
			CH_BANG:  t = TK_BANG;
			CH_SEMI:  t = TK_SEMI;
			CH_LPAR:  t = TK_LPAR;
			CH_RPAR:  t = TK_RPAR;
			CH_LBRC:  t = TK_LBRC;
			CH_RBRC:  t = TK_RBRC;
			CH_LBRK:  t = TK_LBRK;
			CH_RBRK:  t = TK_RBRK;
			default:  t = TK_REJECT;
		endcase
		return t;
	endfunction

endpackage

`default_nettype wire

// ===== src/lst_decode.sv =====
// combinational next-state and token decode for one character
// depends on lst_pkg
`default_nettype none

module lst_decode (
	input  wire logic [lst_pkg::CHAR_W-1:0]  char_in,
	input  wire lst_pkg::lex_state_t         cur,
	output lst_pkg::lex_state_t              nxt,
	output logic [lst_pkg::TOKEN_W-1:0]      token_code
);

	logic [lst_pkg::TOKEN_W-1:0] single;
	logic                        none_pending;

	assign single       = lst_pkg::single_sign(char_in);
	assign none_pending = (cur.pending_sign == lst_pkg::PS_NONE);

	always_comb begin
		nxt        = cur;
		token_code = lst_pkg::TK_REJECT;
		if (cur.in_comment) begin
			if (char_in == lst_pkg::CH_COLON && cur.pending_sign == lst_pkg::PS_STAR) begin
				nxt        = lst_pkg::LEX_RESET;
				token_code = lst_pkg::TK_CMT_END;
			end else begin
				nxt.second_colon = 1'b0;
				nxt.pending_sign = (char_in == lst_pkg::CH_STAR) ? lst_pkg::PS_STAR
					: lst_pkg::PS_NONE;
				token_code = (char_in == lst_pkg::CH_NL) ? lst_pkg::TK_CMT_NL
					: lst_pkg::TK_CMT_BODY;
			end
		end else if (none_pending && !cur.second_colon
				&& single != lst_pkg::TK_REJECT) begin
			token_code = single;
		end else begin
			case (char_in)
				lst_pkg::CH_COLON: begin
					if (none_pending) begin
						nxt.pending_sign = lst_pkg::PS_COLON;
						token_code       = lst_pkg::TK_CONT;
					end else if (cur.pending_sign == lst_pkg::PS_EQ) begin
						nxt.second_colon = 1'b1;
						token_code       = lst_pkg::TK_CONT;
					end else begin
						nxt.pending_sign = lst_pkg::PS_NONE;
						nxt.second_colon = 1'b0;
						token_code       = lst_pkg::TK_COLON;
					end
				end
				lst_pkg::CH_STAR: begin
					if (none_pending) begin
						nxt.pending_sign = lst_pkg::PS_STAR;
						token_code       = lst_pkg::TK_CONT;
					end else if (cur.pending_sign == lst_pkg::PS_COLON) begin
						nxt.in_comment   = 1'b1;
						nxt.pending_sign = lst_pkg::PS_NONE;
						nxt.second_colon = 1'b0;
						token_code       = lst_pkg::TK_CONT;
					end else begin
						// state left as it is
						token_code = lst_pkg::TK_STAR;
					end
				end
				lst_pkg::CH_EQ: begin
					if (none_pending) begin
						nxt.pending_sign = lst_pkg::PS_EQ;
						token_code       = lst_pkg::TK_CONT;
					end else begin
						nxt.pending_sign = lst_pkg::PS_NONE;
						nxt.second_colon = 1'b0;
						if (cur.pending_sign == lst_pkg::PS_COLON)
							token_code = lst_pkg::TK_ASSIGN;
						else if (cur.pending_sign == lst_pkg::PS_EQ && cur.second_colon)
							token_code = lst_pkg::TK_EQCEQ;
						else
							token_code = lst_pkg::TK_EQ;
					end
				end
				lst_pkg::CH_AMP: begin
					if (none_pending) begin
						nxt.pending_sign = lst_pkg::PS_AMP;
						token_code       = lst_pkg::TK_CONT;
					end else begin
						nxt.pending_sign = lst_pkg::PS_NONE;
						nxt.second_colon = 1'b0;
						token_code = (cur.pending_sign == lst_pkg::PS_AMP)
							? lst_pkg::TK_ANDAND : lst_pkg::TK_REJECT;
					end
				end
				default: begin
					nxt.pending_sign = lst_pkg::PS_NONE;
					nxt.second_colon = 1'b0;
					token_code       = lst_pkg::TK_REJECT;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== src/lexer_sign_token_fsm_core.sv =====
// sign-token lexer core: one character in, one token code out per transaction
// a token passes the input register, then the result register; one per cycle if no stall
// the lexer state is updated by the decode between input and result registers
// arst_n clears the lexer state (nothing pending, no second colon, not in a comment)
// and empties both registers; depends on lst_pkg and lst_decode
`default_nettype none

module lexer_sign_token_fsm_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// character channel
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [lst_pkg::CHAR_W-1:0]    char_in,
	// token channel
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [lst_pkg::TOKEN_W-1:0]        token_code
);

	// input register
	logic                          valid_s1;
	logic [lst_pkg::CHAR_W-1:0]    char_s1;

	// lexer state and result register
	lst_pkg::lex_state_t           state_q;
	lst_pkg::lex_state_t           state_nxt;
	logic                          valid_s2;
	logic [lst_pkg::TOKEN_W-1:0]   token_s2;
	logic [lst_pkg::TOKEN_W-1:0]   token_nxt;

	logic                          out_free;
	logic                          advance;
	logic                          accept;

	// result register can take a new token when empty or being drained
	assign out_free = !valid_s2 || !out_stall;
	// input stage hands its character on to the decode this cycle
	assign advance  = valid_s1 && out_free;
	// input register is free when empty or moving on
	assign in_stall = valid_s1 && !out_free;
	assign accept   = in_valid && !in_stall;

	lst_decode u_decode (
		.char_in    (char_s1),
		.cur        (state_q),
		.nxt        (state_nxt),
		.token_code (token_nxt)
	);

	// input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// input payload, no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1 <= char_in;
		end
	end

	// lexer state moves only when a character is decoded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= lst_pkg::LEX_RESET;
			valid_s2 <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_nxt;
			end
			if (out_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (advance) begin
			token_s2 <= token_nxt;
		end
	end

	assign out_valid  = valid_s2;
	assign token_code = token_s2;

endmodule

`default_nettype wire
